// File: hdl/vfab_pkg.sv
// shared types and constants for the vertex-face adjacency builder
package vfab_pkg;

    // default sizes of the face store and the per-vertex table
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_FACES    = 1024;

    // fixed field widths of the item and result ports
    localparam int OPCODE_W = 3;
    localparam int VID_W    = 10;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 12;
    localparam int STATUS_W = 2;
    localparam int VCOUNT_W = 11;

    // vertex count register value after reset
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

    // item opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD_FACE    = 3'd0,
        OP_BUILD       = 3'd1,
        OP_READ_OFFSET = 3'd2,
        OP_READ_LIST   = 3'd3,
        OP_CLEAR_FACES = 3'd4
    } opcode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_VERTEX = 2'd1,
        ST_FULL       = 2'd2,
        ST_BAD_READ   = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CLR,
        S_FACE_RD,
        S_FACE_CHK,
        S_VTX_RD,
        S_VTX_WR,
        S_PFX_RD,
        S_PFX_WR
    } state_t;

endpackage

// File: hdl/vfab_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module vfab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/vertex_face_adjacency_builder.sv
// top level of the vertex-face adjacency builder: sequencer and three rams
//
// Item channel (item_valid/item_ready) carries an opcode, three vertex ids and
// a read index; the result channel (result_valid/result_ready) returns one
// read_value and status per item. cfg_write_en/cfg_write_data set the vertex
// count with no handshake; the user writes it only while idle, which the
// block itself does not enforce. Add face, clear faces and unused opcodes:
// result in the cycle after accept. Reads of a vertex end offset or a list
// entry pass the registered ram read in S_READ, then the result register;
// reads that fail their range check answer in the cycle after accept.
// Build: one shared adder and the vertex table's single read port are walked
// by the sequencer: it clears the counters of all nv vertices, counts the
// faces whose ids are in range (skipping the rest), forms the prefix sum
// and scatters those faces again, nv being the saturated vertex count.
// The block takes one item at a time: item_ready is high only while the
// sequencer is idle and the result register is empty or being emptied.
// A stalled receiver holds the result register and so holds off new items.
// Reset empties the face store count, clears the built mark and result
// register and loads the vertex count with 1024.
module vertex_face_adjacency_builder import vfab_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_FACES    = DEF_MAX_FACES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [VCOUNT_W-1:0] cfg_write_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [VID_W-1:0]    vertex_a,
    input  logic [VID_W-1:0]    vertex_b,
    input  logic [VID_W-1:0]    vertex_c,
    input  logic [INDEX_W-1:0]  read_index,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [VALUE_W-1:0]  read_value,
    output logic [STATUS_W-1:0] status
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int FAW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int LAW = $clog2(3 * MAX_FACES);
    localparam int NVW = $clog2(MAX_VERTICES + 1);
    localparam int FTW = $clog2(MAX_FACES + 1);
    localparam int OW  = $clog2(3 * MAX_FACES + 1);
    localparam int FW  = 3 * VID_W;
    localparam logic [1:0] LAST_K = 2'd2;

    // control and payload registers
    state_t              state_reg, state_next;
    logic [VCOUNT_W-1:0] vcount_reg, vcount_next;
    logic [FTW-1:0]      face_total_reg, face_total_next;
    logic                built_reg, built_next;
    logic [OW-1:0]       list_length_reg, list_length_next;
    logic [NVW-1:0]      built_vertices_reg, built_vertices_next;
    logic [FTW-1:0]      f_reg, f_next;
    logic [NVW-1:0]      v_reg, v_next;
    logic [1:0]          k_reg, k_next;
    logic [OW-1:0]       run_reg, run_next;
    logic                scatter_reg, scatter_next;
    logic                read_list_reg, read_list_next;
    logic [FW-1:0]       face_reg, face_next;
    logic                result_valid_reg, result_valid_next;
    logic [VALUE_W-1:0]  read_value_reg, read_value_next;
    status_t             status_reg, status_next;

    // memory ports
    logic           face_wr_en, face_rd_en;
    logic [FAW-1:0] face_wr_addr, face_rd_addr;
    logic [FW-1:0]  face_wr_data, face_rd_data;
    logic           vtx_wr_en, vtx_rd_en;
    logic [VAW-1:0] vtx_wr_addr, vtx_rd_addr;
    logic [OW-1:0]  vtx_wr_data, vtx_rd_data;
    logic           list_wr_en, list_rd_en;
    logic [LAW-1:0] list_wr_addr, list_rd_addr;
    logic [FAW-1:0] list_wr_data, list_rd_data;

    // misc combinational values
    logic           item_fire;
    logic [NVW-1:0] nv;
    logic           add_ids_ok;
    logic           stored_ids_ok;
    logic [VID_W-1:0] cur_id;
    logic           last_v;
    logic           faces_done;
    logic [OW-1:0]  add_a, add_b, add_sum;
    logic           offset_read_ok, list_read_ok;

    // face store, per-vertex counters/offsets, adjacency list
    vfab_ram #(.WIDTH(FW), .DEPTH(MAX_FACES)) u_face_ram (
        .clk     (clk),
        .wr_en   (face_wr_en),
        .wr_addr (face_wr_addr),
        .wr_data (face_wr_data),
        .rd_en   (face_rd_en),
        .rd_addr (face_rd_addr),
        .rd_data (face_rd_data)
    );

    vfab_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES)) u_vertex_ram (
        .clk     (clk),
        .wr_en   (vtx_wr_en),
        .wr_addr (vtx_wr_addr),
        .wr_data (vtx_wr_data),
        .rd_en   (vtx_rd_en),
        .rd_addr (vtx_rd_addr),
        .rd_data (vtx_rd_data)
    );

    vfab_ram #(.WIDTH(FAW), .DEPTH(3 * MAX_FACES)) u_list_ram (
        .clk     (clk),
        .wr_en   (list_wr_en),
        .wr_addr (list_wr_addr),
        .wr_data (list_wr_data),
        .rd_en   (list_rd_en),
        .rd_addr (list_rd_addr),
        .rd_data (list_rd_data)
    );

    // handshake
    assign item_ready   = (state_reg == S_IDLE) && (!result_valid_reg || result_ready);
    assign item_fire    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign read_value   = read_value_reg;
    assign status       = status_reg;

    // vertex count saturated to 1..MAX_VERTICES
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            nv = NVW'(1);
        end
        else if (32'(vcount_reg) > 32'(MAX_VERTICES))
        begin
            nv = NVW'(MAX_VERTICES);
        end
        else
        begin
            nv = NVW'(vcount_reg);
        end
    end

    // range checks on incoming and stored faces
    assign add_ids_ok = (32'(vertex_a) < 32'(nv)) && (32'(vertex_b) < 32'(nv))
                     && (32'(vertex_c) < 32'(nv));
    assign stored_ids_ok = (32'(face_rd_data[VID_W-1:0]) < 32'(nv))
                        && (32'(face_rd_data[2*VID_W-1:VID_W]) < 32'(nv))
                        && (32'(face_rd_data[3*VID_W-1:2*VID_W]) < 32'(nv));

    // read range checks
    assign offset_read_ok = built_reg && (32'(read_index) < 32'(built_vertices_reg));
    assign list_read_ok   = built_reg && (32'(read_index) < 32'(list_length_reg));

    // vertex id of the current corner
    always_comb
    begin
        unique case (k_reg)
            2'd0:    cur_id = face_reg[VID_W-1:0];
            2'd1:    cur_id = face_reg[2*VID_W-1:VID_W];
            default: cur_id = face_reg[3*VID_W-1:2*VID_W];
        endcase
    end

    assign last_v     = (v_reg == nv - NVW'(1));
    assign faces_done = (f_reg == face_total_reg);

    // shared adder: running prefix sum or counter/offset increment
    assign add_a   = (state_reg == S_PFX_WR) ? run_reg : vtx_rd_data;
    assign add_b   = (state_reg == S_PFX_WR) ? vtx_rd_data : OW'(1);
    assign add_sum = add_a + add_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    priority if (opcode == OP_BUILD)
                        state_next = S_CLR;
                    else if (opcode == OP_READ_OFFSET && offset_read_ok)
                        state_next = S_READ;
                    else if (opcode == OP_READ_LIST && list_read_ok)
                        state_next = S_READ;
                    else
                        state_next = S_IDLE;
                end
            end
            S_READ:
                state_next = S_IDLE;
            S_CLR:
                state_next = last_v ? S_FACE_RD : S_CLR;
            S_FACE_RD:
            begin
                if (faces_done)
                    state_next = scatter_reg ? S_IDLE : S_PFX_RD;
                else
                    state_next = S_FACE_CHK;
            end
            S_FACE_CHK:
                state_next = stored_ids_ok ? S_VTX_RD : S_FACE_RD;
            S_VTX_RD:
                state_next = S_VTX_WR;
            S_VTX_WR:
                state_next = (k_reg == LAST_K) ? S_FACE_RD : S_VTX_RD;
            S_PFX_RD:
                state_next = S_PFX_WR;
            S_PFX_WR:
                state_next = last_v ? S_FACE_RD : S_PFX_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath control, memory ports and register updates
    always_comb
    begin
        vcount_next         = cfg_write_en ? cfg_write_data : vcount_reg;
        face_total_next     = face_total_reg;
        built_next          = built_reg;
        list_length_next    = list_length_reg;
        built_vertices_next = built_vertices_reg;
        f_next              = f_reg;
        v_next              = v_reg;
        k_next              = k_reg;
        run_next            = run_reg;
        scatter_next        = scatter_reg;
        read_list_next      = read_list_reg;
        face_next           = face_reg;
        result_valid_next   = result_valid_reg && !result_ready;
        read_value_next     = read_value_reg;
        status_next         = status_reg;

        face_wr_en   = 1'b0;
        face_wr_addr = FAW'(face_total_reg);
        face_wr_data = {vertex_c, vertex_b, vertex_a};
        face_rd_en   = 1'b0;
        face_rd_addr = FAW'(f_reg);
        vtx_wr_en    = 1'b0;
        vtx_wr_addr  = VAW'(v_reg);
        vtx_wr_data  = '0;
        vtx_rd_en    = 1'b0;
        vtx_rd_addr  = VAW'(v_reg);
        list_wr_en   = 1'b0;
        list_wr_addr = LAW'(vtx_rd_data);
        list_wr_data = FAW'(f_reg);
        list_rd_en   = 1'b0;
        list_rd_addr = LAW'(read_index);

        unique case (state_reg)
            // accept an item
            S_IDLE:
            begin
                if (item_fire)
                begin
                    read_value_next = '0;
                    status_next     = ST_OK;
                    unique case (opcode)
                        OP_ADD_FACE:
                        begin
                            result_valid_next = 1'b1;
                            priority if (!add_ids_ok)
                                status_next = ST_BAD_VERTEX;
                            else if (32'(face_total_reg) >= 32'(MAX_FACES))
                                status_next = ST_FULL;
                            else
                            begin
                                face_wr_en      = 1'b1;
                                face_total_next = face_total_reg + FTW'(1);
                                built_next      = 1'b0;
                            end
                        end
                        OP_BUILD:
                        begin
                            v_next       = '0;
                            f_next       = '0;
                            run_next     = '0;
                            scatter_next = 1'b0;
                        end
                        OP_READ_OFFSET:
                        begin
                            read_list_next = 1'b0;
                            vtx_rd_addr    = VAW'(read_index);
                            if (offset_read_ok)
                                vtx_rd_en = 1'b1;
                            else
                            begin
                                result_valid_next = 1'b1;
                                status_next       = ST_BAD_READ;
                            end
                        end
                        OP_READ_LIST:
                        begin
                            read_list_next = 1'b1;
                            if (list_read_ok)
                                list_rd_en = 1'b1;
                            else
                            begin
                                result_valid_next = 1'b1;
                                status_next       = ST_BAD_READ;
                            end
                        end
                        OP_CLEAR_FACES:
                        begin
                            result_valid_next = 1'b1;
                            face_total_next   = '0;
                            built_next        = 1'b0;
                        end
                        default:
                            result_valid_next = 1'b1;
                    endcase
                end
            end
            // ram read data ready, return it
            S_READ:
            begin
                result_valid_next = 1'b1;
                status_next       = ST_OK;
                read_value_next   = read_list_reg ? VALUE_W'(list_rd_data)
                                                  : VALUE_W'(vtx_rd_data);
            end
            // zero the per-vertex counters
            S_CLR:
            begin
                vtx_wr_en = 1'b1;
                v_next    = last_v ? '0 : v_reg + NVW'(1);
            end
            // fetch the next face, or close a phase
            S_FACE_RD:
            begin
                if (faces_done)
                begin
                    v_next = '0;
                    if (scatter_reg)
                    begin
                        built_next          = 1'b1;
                        list_length_next    = run_reg;
                        built_vertices_next = nv;
                        result_valid_next   = 1'b1;
                        read_value_next     = '0;
                        status_next         = ST_OK;
                    end
                end
                else
                    face_rd_en = 1'b1;
            end
            // skip faces whose ids are out of range
            S_FACE_CHK:
            begin
                face_next = face_rd_data;
                k_next    = '0;
                if (!stored_ids_ok)
                    f_next = f_reg + FTW'(1);
            end
            // read the counter or offset of the current corner
            S_VTX_RD:
            begin
                vtx_rd_en   = 1'b1;
                vtx_rd_addr = VAW'(cur_id);
            end
            // bump it, and in the scatter place the face number
            S_VTX_WR:
            begin
                vtx_wr_en   = 1'b1;
                vtx_wr_addr = VAW'(cur_id);
                vtx_wr_data = add_sum;
                list_wr_en  = scatter_reg;
                if (k_reg == LAST_K)
                    f_next = f_reg + FTW'(1);
                else
                    k_next = k_reg + 2'd1;
            end
            // prefix sum: read a count
            S_PFX_RD:
            begin
                vtx_rd_en = 1'b1;
            end
            // write the start offset, accumulate the count
            S_PFX_WR:
            begin
                vtx_wr_en   = 1'b1;
                vtx_wr_data = run_reg;
                run_next    = add_sum;
                if (last_v)
                begin
                    v_next       = '0;
                    f_next       = '0;
                    scatter_next = 1'b1;
                end
                else
                    v_next = v_reg + NVW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            vcount_reg         <= VCOUNT_RESET;
            face_total_reg     <= '0;
            built_reg          <= 1'b0;
            list_length_reg    <= '0;
            built_vertices_reg <= '0;
            f_reg              <= '0;
            v_reg              <= '0;
            k_reg              <= '0;
            run_reg            <= '0;
            scatter_reg        <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            vcount_reg         <= vcount_next;
            face_total_reg     <= face_total_next;
            built_reg          <= built_next;
            list_length_reg    <= list_length_next;
            built_vertices_reg <= built_vertices_next;
            f_reg              <= f_next;
            v_reg              <= v_next;
            k_reg              <= k_next;
            run_reg            <= run_next;
            scatter_reg        <= scatter_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        read_list_reg  <= read_list_next;
        face_reg       <= face_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

endmodule
